### rtl/core/mss_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mss_pkg: shared types and constants of the maximum run sum search
// Widths, transaction payloads, sequencer states and stack frame layout.
// ============================================================================
package mss_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = 14;
    localparam int SW    = 45;
    localparam int SD    = AW + 1;
    localparam int SPW   = $clog2(SD + 1);

    typedef struct packed {
        logic signed [31:0] sample;
        logic               is_last;
    } t_in;

    typedef struct packed {
        logic signed [SW-1:0] max_sum;
        logic [12:0]          start_index;
        logic [12:0]          end_index;
        logic                 overflowed;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD, S_ENTER, S_LEAF_RD, S_LEAF_AC, S_SL_RD, S_SL_AC,
        S_SR_RD, S_SR_AC, S_CSUM, S_CMP, S_RET, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        P_FRESH, P_LEFT, P_RIGHT
    } t_phase;

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic [AW-1:0]        first;
        logic [AW-1:0]        last;
    } t_run;

    typedef struct packed {
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
        t_phase        phase;
        t_run          left;
    } t_frame;

endpackage

### rtl/core/mss_store.sv
`timescale 1ns / 1ps
// ============================================================================
// mss_store: sample memory
// One write port, one read port with registered read data.
// ============================================================================
module mss_store (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [mss_pkg::AW-1:0]  i_waddr,
    input  logic [31:0]             i_wdata,
    input  logic [mss_pkg::AW-1:0]  i_raddr,
    output logic [31:0]             o_rdata
);

    logic [31:0] r_mem [mss_pkg::DEPTH];
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

### rtl/core/max_subarray_sum_with_bounds_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// max_subarray_sum_with_bounds_unit: maximum contiguous run sum search
// Loads signed samples, then finds the best run by recursive halving.
// ============================================================================
// Usage:
// Samples arrive on the input channel, one per transaction, and are written
// to the sample store as they are taken. Samples beyond DEPTH are dropped and
// remembered in the overflow flag. A transaction with is_last set closes the
// sequence and starts the search; o_in_stall stays high until it is done.
// The search walks the halving recursion with a small frame stack. Each
// inner range makes two crossing scans, with one store read per element and
// a single shared accumulator, so the one read port of the store sets the
// pace of the search.
// The result leaves through an output register as one transaction. While the
// receiver stalls it holds steady, and the next sequence may already load;
// a second search waits only until the register is free.
// Reset (synchronous, active low) empties the store count, clears the
// overflow flag, the stack pointer and the output valid. Stored samples are
// not cleared; only samples of the current sequence are ever read.
// ============================================================================
module max_subarray_sum_with_bounds_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mss_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mss_pkg::t_out  o_out_data
);

    mss_pkg::t_state r_state, n_state;

    // Frame stack of the recursion; the top frame is the range in work.
    mss_pkg::t_frame r_stk [mss_pkg::SD];
    logic [mss_pkg::SPW-1:0] r_sp;

    logic [mss_pkg::CW-1:0] r_cnt;
    logic                   r_drop;
    logic                   r_ovf;

    logic [mss_pkg::AW-1:0]        r_k;
    logic signed [mss_pkg::SW-1:0] r_acc;
    logic signed [mss_pkg::SW-1:0] r_bl, r_br, r_cross;
    logic [mss_pkg::AW-1:0]        r_atl, r_atr;
    mss_pkg::t_run                 r_ret;

    logic                  r_out_valid;
    mss_pkg::t_out         r_out;

    logic [31:0]           w_q;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_we;
    mss_pkg::t_frame       w_f;
    logic [mss_pkg::SPW-1:0] w_sp1;
    logic [mss_pkg::AW:0]  w_lohi;
    logic [mss_pkg::AW-1:0] w_mid;
    logic signed [mss_pkg::SW-1:0] w_sx;
    logic signed [mss_pkg::SW-1:0] w_accn;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_full   = (r_cnt >= mss_pkg::CW'(mss_pkg::DEPTH));
    assign w_we     = w_accept && !w_full;
    assign w_f      = r_stk[r_sp];
    assign w_sp1    = r_sp + 1'b1;
    assign w_lohi   = {1'b0, w_f.lo} + {1'b0, w_f.hi};
    assign w_mid    = w_lohi[mss_pkg::AW:1];
    assign w_sx     = {{(mss_pkg::SW-32){w_q[31]}}, w_q};
    assign w_accn   = r_acc + w_sx;

    mss_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[mss_pkg::AW-1:0]),
        .i_wdata (i_in_data.sample),
        .i_raddr (r_k),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mss_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            mss_pkg::S_LOAD: begin
                o_in_stall = 1'b0;
                if (w_accept && i_in_data.is_last) begin
                    n_state = mss_pkg::S_ENTER;
                end
            end
            mss_pkg::S_ENTER: begin
                unique case (w_f.phase)
                    mss_pkg::P_FRESH: begin
                        if (w_f.lo == w_f.hi) begin
                            n_state = mss_pkg::S_LEAF_RD;
                        end
                    end
                    mss_pkg::P_LEFT: n_state = mss_pkg::S_ENTER;
                    default:         n_state = mss_pkg::S_SL_RD;
                endcase
            end
            mss_pkg::S_LEAF_RD: n_state = mss_pkg::S_LEAF_AC;
            mss_pkg::S_LEAF_AC: n_state = mss_pkg::S_RET;
            mss_pkg::S_SL_RD:   n_state = mss_pkg::S_SL_AC;
            mss_pkg::S_SL_AC: begin
                n_state = (r_k == w_f.lo) ? mss_pkg::S_SR_RD : mss_pkg::S_SL_RD;
            end
            mss_pkg::S_SR_RD:   n_state = mss_pkg::S_SR_AC;
            mss_pkg::S_SR_AC: begin
                n_state = (r_k == w_f.hi) ? mss_pkg::S_CSUM : mss_pkg::S_SR_RD;
            end
            mss_pkg::S_CSUM:    n_state = mss_pkg::S_CMP;
            mss_pkg::S_CMP:     n_state = mss_pkg::S_RET;
            mss_pkg::S_RET: begin
                n_state = (r_sp == '0) ? mss_pkg::S_OUT : mss_pkg::S_ENTER;
            end
            mss_pkg::S_OUT: begin
                if (!r_out_valid) begin
                    n_state = mss_pkg::S_LOAD;
                end
            end
            default: n_state = mss_pkg::S_LOAD;
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                mss_pkg::S_LOAD: begin
                    if (w_accept) begin
                        if (i_in_data.is_last) begin
                            r_cnt  <= '0;
                            r_drop <= 1'b0;
                            r_sp   <= '0;
                        end else if (w_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                mss_pkg::S_ENTER: begin
                    if (w_f.phase == mss_pkg::P_LEFT ||
                        (w_f.phase == mss_pkg::P_FRESH && w_f.lo != w_f.hi)) begin
                        r_sp <= r_sp + 1'b1;
                    end
                end
                mss_pkg::S_RET: begin
                    if (r_sp != '0) begin
                        r_sp <= r_sp - 1'b1;
                    end
                end
                mss_pkg::S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mss_pkg::S_LOAD: begin
                if (w_accept && i_in_data.is_last) begin
                    r_ovf          <= r_drop | w_full;
                    r_stk[0].lo    <= '0;
                    r_stk[0].hi    <= w_full ? mss_pkg::AW'(mss_pkg::DEPTH - 1)
                                             : r_cnt[mss_pkg::AW-1:0];
                    r_stk[0].phase <= mss_pkg::P_FRESH;
                end
            end
            mss_pkg::S_ENTER: begin
                unique case (w_f.phase)
                    mss_pkg::P_FRESH: begin
                        if (w_f.lo == w_f.hi) begin
                            r_k <= w_f.lo;
                        end else begin
                            r_stk[r_sp].phase   <= mss_pkg::P_LEFT;
                            r_stk[w_sp1].lo     <= w_f.lo;
                            r_stk[w_sp1].hi     <= w_mid;
                            r_stk[w_sp1].phase  <= mss_pkg::P_FRESH;
                        end
                    end
                    mss_pkg::P_LEFT: begin
                        r_stk[r_sp].left    <= r_ret;
                        r_stk[r_sp].phase   <= mss_pkg::P_RIGHT;
                        r_stk[w_sp1].lo     <= w_mid + 1'b1;
                        r_stk[w_sp1].hi     <= w_f.hi;
                        r_stk[w_sp1].phase  <= mss_pkg::P_FRESH;
                    end
                    default: begin
                        r_k   <= w_mid;
                        r_acc <= '0;
                    end
                endcase
            end
            mss_pkg::S_LEAF_AC: begin
                r_ret.sum   <= w_sx;
                r_ret.first <= w_f.lo;
                r_ret.last  <= w_f.lo;
            end
            mss_pkg::S_SL_AC: begin
                if (r_k == w_mid || w_accn > r_bl) begin
                    r_bl  <= w_accn;
                    r_atl <= r_k;
                end
                if (r_k == w_f.lo) begin
                    r_k   <= w_mid + 1'b1;
                    r_acc <= '0;
                end else begin
                    r_k   <= r_k - 1'b1;
                    r_acc <= w_accn;
                end
            end
            mss_pkg::S_SR_AC: begin
                if (r_k == w_mid + 1'b1 || w_accn > r_br) begin
                    r_br  <= w_accn;
                    r_atr <= r_k;
                end
                r_acc <= w_accn;
                if (r_k != w_f.hi) begin
                    r_k <= r_k + 1'b1;
                end
            end
            mss_pkg::S_CSUM: r_cross <= r_bl + r_br;
            mss_pkg::S_CMP: begin
                // Left half wins ties, then right half, then the crossing run.
                priority if (w_f.left.sum >= r_ret.sum && w_f.left.sum >= r_cross) begin
                    r_ret <= w_f.left;
                end else if (r_ret.sum >= r_cross) begin
                    r_ret <= r_ret;
                end else begin
                    r_ret.sum   <= r_cross;
                    r_ret.first <= r_atl;
                    r_ret.last  <= r_atr;
                end
            end
            mss_pkg::S_OUT: begin
                if (!r_out_valid) begin
                    r_out.max_sum     <= r_ret.sum;
                    r_out.start_index <= 13'(r_ret.first);
                    r_out.end_index   <= 13'(r_ret.last);
                    r_out.overflowed  <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/core/mss_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mss_checker: port level checks of the run sum search
// Watches the top level's channels and result fields.
// ============================================================================
module mss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input mss_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input mss_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.start_index <= o_out_data.end_index)
        else $error("run start after run end");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.end_index < 13'(mss_pkg::DEPTH))
        else $error("run end beyond store depth");

endmodule

bind max_subarray_sum_with_bounds_unit mss_checker u_mss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
